FILE: hdl/lzwd_pkg.sv
`default_nettype none

package lzwd_pkg;

   // default geometry
   localparam int DEF_POS_BITS  = 12;
   localparam int DEF_LEN_BITS  = 4;
   localparam int DEF_MAX_MATCH = 18;

   // shortest match that a length code describes
   localparam int MIN_LEN = 3;

   // value of a window byte never written since reset
   localparam logic [7:0] FILL_BYTE = 8'h20;

   // token kinds
   localparam logic CMD_LITERAL = 1'b0;
   localparam logic CMD_MATCH   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic tok_load;
      logic rd_step;
      logic emit_step;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rd_last;
      logic em_last;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: hdl/lzwd_ctrl.sv
`default_nettype none

module lzwd_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_cmd,
   output logic                    req_ready,
   input  wire lzwd_pkg::dp_stat_type stat,
   output lzwd_pkg::dp_cmd_type    cmd
);
   import lzwd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      cmd.tok_load  = 1'b0;
      cmd.rd_step   = 1'b0;
      cmd.emit_step = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.tok_load = 1'b1;
               state_in     = (req_cmd == CMD_MATCH) ? ST_READ : ST_EMIT;
            end
         end
         ST_READ: begin
            cmd.rd_step = 1'b1;
            if (stat.rd_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last window read lands in the snapshot
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_step = 1'b1;
               if (stat.em_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/lzwd_dpath.sv
`default_nettype none

module lzwd_dpath #(
   parameter int POS_BITS  = lzwd_pkg::DEF_POS_BITS,
   parameter int LEN_BITS  = lzwd_pkg::DEF_LEN_BITS,
   parameter int MAX_MATCH = lzwd_pkg::DEF_MAX_MATCH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lzwd_pkg::dp_cmd_type  cmd,
   output lzwd_pkg::dp_stat_type      stat,
   input  wire logic                  req_cmd,
   input  wire logic [7:0]            req_literal_byte,
   input  wire logic [LEN_BITS-1:0]   req_match_len_code,
   input  wire logic [POS_BITS-1:0]   req_match_pos,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last
);
   import lzwd_pkg::*;

   localparam int WINDOW_SIZE = 1 << POS_BITS;
   localparam int IDX_W       = $clog2(MAX_MATCH);
   localparam int SUM_W       = LEN_BITS + 2;

   // ring window and copy snapshot
   logic [7:0] window_mem [WINDOW_SIZE];
   logic [7:0] snap_ff    [MAX_MATCH];

   logic [POS_BITS-1:0] wp_ff;
   logic                wrapped_ff;
   logic [POS_BITS-1:0] pos_ff;
   logic [IDX_W-1:0]    lenm1_ff;
   logic [IDX_W-1:0]    rd_cnt_ff;
   logic [IDX_W-1:0]    em_cnt_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic                fill_ok_ff;
   logic [7:0]          rd_data_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_byte_ff;
   logic                rsp_last_ff;

   logic [SUM_W-1:0]    lenm1_full;
   logic [IDX_W-1:0]    lenm1_in;
   logic [POS_BITS-1:0] rd_addr;
   logic [7:0]          em_byte;

   // length minus one, saturated at the longest match
   always_comb begin
      lenm1_full = SUM_W'(req_match_len_code) + SUM_W'(MIN_LEN - 1);
      if (req_cmd == CMD_LITERAL) begin
         lenm1_in = '0;
      end else if (int'(lenm1_full) >= MAX_MATCH - 1) begin
         lenm1_in = IDX_W'(MAX_MATCH - 1);
      end else begin
         lenm1_in = IDX_W'(lenm1_full);
      end
   end

   assign rd_addr = pos_ff + POS_BITS'(rd_cnt_ff);
   assign em_byte = snap_ff[em_cnt_ff];

   // token registers and counters
   always_ff @(posedge clock) begin
      if (cmd.tok_load) begin
         pos_ff    <= req_match_pos;
         lenm1_ff  <= lenm1_in;
         rd_cnt_ff <= '0;
         em_cnt_ff <= '0;
      end else begin
         if (cmd.rd_step) begin
            rd_cnt_ff <= rd_cnt_ff + IDX_W'(1);
         end
         if (cmd.emit_step) begin
            em_cnt_ff <= em_cnt_ff + IDX_W'(1);
         end
      end
   end

   // window memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.emit_step) begin
         window_mem[wp_ff] <= em_byte;
      end
      rd_data_ff <= window_mem[rd_addr];
   end

   // read tracking; before the pointer wraps, an entry at or above the fill mark reads as the fill byte
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_step;
      end
      rd_idx_ff  <= rd_cnt_ff;
      fill_ok_ff <= wrapped_ff || (rd_addr < wp_ff);
   end

   // snapshot capture
   always_ff @(posedge clock) begin
      if (cmd.tok_load && req_cmd == CMD_LITERAL) begin
         snap_ff[0] <= req_literal_byte;
      end else if (rd_vld_ff) begin
         snap_ff[rd_idx_ff] <= fill_ok_ff ? rd_data_ff : FILL_BYTE;
      end
   end

   // write pointer and fill mark
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         wrapped_ff <= 1'b0;
      end else if (cmd.emit_step) begin
         wp_ff <= wp_ff + POS_BITS'(1);
         if (wp_ff == POS_BITS'(WINDOW_SIZE - 1)) begin
            wrapped_ff <= 1'b1;
         end
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_step) begin
         rsp_byte_ff <= em_byte;
         rsp_last_ff <= (em_cnt_ff == lenm1_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // status
   assign stat.rd_last  = (rd_cnt_ff == lenm1_ff);
   assign stat.em_last  = (em_cnt_ff == lenm1_ff);
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

FILE: hdl/lz77_window_decoder.sv
// LZ77 window decoder: expands pre-split literal and match tokens into bytes.
// req_ channel: one token per word (req_cmd selects literal or match).
// rsp_ channel: one output byte per word, rsp_last high on the token's final byte.
// A match reads its source bytes from the ring window into a snapshot, one
// window read per cycle, then writes and emits them, one byte per cycle while
// the receiver keeps up. A literal byte goes into the snapshot on acceptance
// and then out through the output register; a match first passes its READ
// and DRAIN states. No new token is taken until the current token's last byte
// has been emitted, so with a receiver that keeps up the rate is set by the
// single window read port and the single write port.
// The next token is taken while the final byte still waits in the output
// register. When the receiver stalls, emission holds and the window write
// pointer stops with it; no byte is dropped.
// Reset clears the write pointer and the fill mark: window bytes not yet
// written since reset read as a space, so no clearing pass is needed and the
// block takes tokens from the first cycle after reset.
`default_nettype none

module lz77_window_decoder #(
   parameter int POS_BITS  = lzwd_pkg::DEF_POS_BITS,
   parameter int LEN_BITS  = lzwd_pkg::DEF_LEN_BITS,
   parameter int MAX_MATCH = lzwd_pkg::DEF_MAX_MATCH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_cmd,
   input  wire logic [7:0]          req_literal_byte,
   input  wire logic [LEN_BITS-1:0] req_match_len_code,
   input  wire logic [POS_BITS-1:0] req_match_pos,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [7:0]               rsp_out_byte,
   output logic                     rsp_last
);
   import lzwd_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // sequencer
   lzwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // window, snapshot and output register
   lzwd_dpath #(
      .POS_BITS  (POS_BITS),
      .LEN_BITS  (LEN_BITS),
      .MAX_MATCH (MAX_MATCH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_cmd            (req_cmd),
      .req_literal_byte   (req_literal_byte),
      .req_match_len_code (req_match_len_code),
      .req_match_pos      (req_match_pos),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last)
   );

endmodule

`default_nettype wire

FILE: hdl/lzwd_checker.sv
`default_nettype none

module lzwd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last
);

   // a stalled output word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("output word changed while stalled");

   // no output word straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output word valid after reset");

   // a token is never followed by another in the next cycle
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("token taken in consecutive cycles");

   // no new token while a token's bytes are still being produced
   a_mid_token: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("token taken in the middle of a match");

endmodule

bind lz77_window_decoder lzwd_checker u_lzwd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;
   import lzwd_pkg::*;

   localparam int POS_W       = DEF_POS_BITS;
   localparam int LEN_W       = DEF_LEN_BITS;
   localparam int LONGEST     = DEF_MAX_MATCH;
   localparam int WIN_DEPTH   = 1 << POS_W;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE      = 48;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_word_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // block ports
   logic             req_valid          = 1'b0;
   logic             req_ready;
   logic             req_cmd            = CMD_LITERAL;
   logic [7:0]       req_literal_byte   = 8'h00;
   logic [LEN_W-1:0] req_match_len_code = '0;
   logic [POS_W-1:0] req_match_pos      = '0;
   logic             rsp_valid;
   logic             rsp_ready          = 1'b0;
   logic [7:0]       rsp_out_byte;
   logic             rsp_last;

   lz77_window_decoder i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_literal_byte   (req_literal_byte),
      .req_match_len_code (req_match_len_code),
      .req_match_pos      (req_match_pos),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last)
   );

   // shadow copy of the ring window and its write pointer
   logic [7:0]       shadow_window [WIN_DEPTH];
   logic [POS_W-1:0] shadow_wr_ptr;
   bit               wr_ptr_wrapped;
   out_word_type     pending_bytes [$];

   int tx_idle_pct   = 0;
   int rx_idle_pct   = 0;
   int hold_cycles   = 0;
   int cycle_count   = 0;
   int mismatch_count = 0;

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // expected bytes of one accepted token, window updated as the block does
   function automatic void decode_token(input logic cmd, input logic [7:0] lit,
                                        input logic [LEN_W-1:0] code,
                                        input logic [POS_W-1:0] pos);
      logic [7:0]       snap [LONGEST];
      int               run_len;
      logic [POS_W-1:0] idx;
      if (cmd == CMD_LITERAL) begin
         shadow_window[shadow_wr_ptr] = lit;
         pending_bytes.push_back('{data: lit, last: 1'b1});
         shadow_wr_ptr = shadow_wr_ptr + POS_W'(1);
         if (shadow_wr_ptr == '0)
            wr_ptr_wrapped = 1'b1;
      end else begin
         run_len = int'(code) + MIN_LEN;
         if (run_len > LONGEST)
            run_len = LONGEST;
         // snapshot first, so an overlapping copy sees the old contents
         for (int i = 0; i < run_len; i++) begin
            idx     = pos + POS_W'(i);
            snap[i] = shadow_window[idx];
         end
         for (int i = 0; i < run_len; i++) begin
            idx = shadow_wr_ptr + POS_W'(i);
            shadow_window[idx] = snap[i];
            pending_bytes.push_back('{data: snap[i], last: (i == run_len - 1)});
         end
         if (int'(shadow_wr_ptr) + run_len >= WIN_DEPTH)
            wr_ptr_wrapped = 1'b1;
         shadow_wr_ptr = shadow_wr_ptr + POS_W'(run_len);
      end
   endfunction

   // offer one token, hold it until taken, then predict its bytes
   task automatic send_token(input logic cmd, input logic [7:0] lit,
                             input logic [LEN_W-1:0] code,
                             input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_cmd            <= cmd;
      req_literal_byte   <= lit;
      req_match_len_code <= code;
      req_match_pos      <= pos;
      do
         @(posedge clock);
      while (!req_ready);
      decode_token(cmd, lit, code, pos);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // random token, mostly matches, half of them copying recently written bytes
   task automatic send_random_token();
      logic [LEN_W-1:0] code;
      logic [POS_W-1:0] pos;
      int               pick;
      code = ($urandom_range(99) < 50) ? '1 : LEN_W'($urandom_range(WIN_DEPTH));
      pick = $urandom_range(3);
      case (pick)
         0: begin
            pos = POS_W'($urandom);
         end
         1: begin
            pos = shadow_wr_ptr - POS_W'($urandom_range(300, 1));
         end
         2: begin
            // source can overlap the bytes being written
            pos = shadow_wr_ptr - POS_W'($urandom_range(LONGEST - 1, 1));
         end
         default: begin
            // source can run over the top of the window
            pos = '1 - POS_W'($urandom_range(LONGEST - 1, 0));
         end
      endcase
      if ($urandom_range(99) < 20)
         send_token(CMD_LITERAL, 8'($urandom), code, pos);
      else
         send_token(CMD_MATCH, 8'($urandom), code, pos);
   endtask

   // receiver: long hold-off when asked, else random stalls
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // compare each output word with the oldest expected byte
   always @(posedge clock) begin : check_words
      out_word_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch($sformatf("word 0x%02h with nothing expected", rsp_out_byte));
         end else begin
            exp_word = pending_bytes.pop_front();
            if (rsp_out_byte !== exp_word.data)
               report_mismatch($sformatf("byte 0x%02h, expected 0x%02h",
                                         rsp_out_byte, exp_word.data));
            if (rsp_last !== exp_word.last)
               report_mismatch($sformatf("last %b, expected %b", rsp_last, exp_word.last));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // field extremes, untouched window, overlap and ignored fields
   task automatic test_directed();
      send_token(CMD_LITERAL, 8'h00, '0, '0);
      send_token(CMD_LITERAL, 8'hFF, '1, '1);
      send_token(CMD_LITERAL, 8'h55, '0, '1);
      send_token(CMD_LITERAL, 8'hAA, '1, '0);
      send_token(CMD_LITERAL, 8'h41, 4'h5, 12'hA5A);
      // untouched window reads as spaces, shortest and longest match
      send_token(CMD_MATCH, 8'h00, '0, 12'd2048);
      send_token(CMD_MATCH, 8'hFF, '1, 12'd1000);
      // copy back the first bytes, running into the spaces
      send_token(CMD_MATCH, 8'h00, '1, '0);
      send_token(CMD_MATCH, 8'h5A, '0, 12'd1);
      // overlapping copy returns the old window contents
      send_token(CMD_LITERAL, 8'h7E, '0, '0);
      send_token(CMD_MATCH, 8'h00, 4'd4, shadow_wr_ptr - POS_W'(1));
      send_token(CMD_MATCH, 8'hFF, '1, shadow_wr_ptr - POS_W'(2));
      send_token(CMD_MATCH, 8'h00, '1, shadow_wr_ptr);
      // source running over the top of the window
      send_token(CMD_MATCH, 8'h00, '1, '1);
      send_token(CMD_MATCH, 8'hC3, '1, 12'hFF8);
      send_token(CMD_MATCH, 8'h00, 4'd7, 12'h800);
      send_token(CMD_LITERAL, 8'h80, '1, 12'h800);
      send_token(CMD_LITERAL, 8'h01, 4'h8, 12'h7FF);
      send_token(CMD_MATCH, 8'h00, 4'h8, shadow_wr_ptr - POS_W'(6));
      send_token(CMD_MATCH, 8'hFF, 4'h1, 12'h555);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_random_phase(input int tx_pct, input int rx_pct, input int count);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (count) send_random_token();
      stop_sending();
      wait_drained();
   endtask

   // receiver holds off while tokens keep coming, so the block stalls its input
   task automatic test_backpressure();
      tx_idle_pct = 0;
      rx_idle_pct = 10;
      hold_cycles = 400;
      repeat (30) send_random_token();
      stop_sending();
      wait_drained();
   endtask

   // long matches until the write pointer has gone round the window
   task automatic test_pointer_wrap();
      tx_idle_pct = 5;
      rx_idle_pct = 5;
      while (!wr_ptr_wrapped)
         send_token(CMD_MATCH, 8'($urandom), '1, POS_W'($urandom));
      send_token(CMD_MATCH, 8'h00, '1, 12'hFF8);
      send_token(CMD_MATCH, 8'h00, '1, shadow_wr_ptr - POS_W'(LONGEST + 4));
      send_token(CMD_LITERAL, 8'($urandom), '1, '1);
      send_token(CMD_MATCH, 8'h00, 4'd9, shadow_wr_ptr - POS_W'(3));
      stop_sending();
      wait_drained();
   endtask

   initial begin
      for (int i = 0; i < WIN_DEPTH; i++)
         shadow_window[i] = FILL_BYTE;
      shadow_wr_ptr  = '0;
      wr_ptr_wrapped = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_phase(21, 73, 100);
      test_random_phase(73, 21, 100);
      test_random_phase(0, 0, 90);
      test_backpressure();
      test_pointer_wrap();

      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

FILE: lz77_window_decoder.f
hdl/lzwd_pkg.sv
hdl/lzwd_ctrl.sv
hdl/lzwd_dpath.sv
hdl/lz77_window_decoder.sv
hdl/lzwd_checker.sv
dv/testbench.sv
